### sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define URAD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("deframer assertion failed");

// A condition that must be followed by a consequence at the next edge.
`define URAD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
	else $error("deframer assertion failed");

`endif

### sv/urad_pkg.sv
// Types and constants shared by the receive deframer modules.
package urad_pkg;

	localparam int HEADER_BYTES     = 4;
	localparam int DESCRIPTOR_BYTES = 16;
	localparam int TRAILER_BYTES    = 4;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam logic [15:0] LEN_ALIGN_MASK = 16'h0003;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HEAD = 2'd1,
		PH_PAY  = 2'd2,
		PH_TRL  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_SHORT   = 3'd1,
		ERR_ZERO    = 3'd2,
		ERR_OVERRUN = 3'd3,
		ERR_ALIGN   = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       frame_last;
		err_t       error_code;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### sv/usb_rx_aggregate_deframer_core.sv
// Top level of the receive deframer: front, result queue and back.
//
// Bytes of a received bulk transfer enter on the input channel (in_valid,
// in_stall, data_byte, first_of_transfer, transfer_length), one request per
// byte. Each byte yields at most one result on the output channel (out_valid,
// out_stall, payload_byte, frame_last, error_code): a payload byte, marked on
// the last of its frame, or a single error result that ends the transfer.
// Header bytes yield only error results; trailer and dropped bytes yield nothing.
// The rx_enable register is written through cfg_valid and cfg_data; cfg_ready
// is always high. Write it only while no byte is in flight.
// A result passes through the result queue and then the output register. One
// byte is taken every cycle while in_stall is low; the front part updates its
// frame state for each accepted byte. Results wait in a queue of QUEUE_DEPTH
// entries, and in_stall rises once that queue is full, so a stalling receiver
// holds back the input after QUEUE_DEPTH plus one results. Reset clears the
// queue, the output valid flag, the frame state and rx_enable, so every byte
// is dropped until the block is enabled and a new transfer starts.
module usb_rx_aggregate_deframer_core import urad_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_of_transfer,
	input  logic [15:0] transfer_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        frame_last,
	output logic [2:0]  error_code
);

	q_status_t q_st;
	logic      push;
	logic      pop;
	res_t      push_res;
	res_t      pop_res;
	res_t      out_res;

	assign cfg_ready    = 1'b1;
	assign payload_byte = out_res.payload_byte;
	assign frame_last   = out_res.frame_last;
	assign error_code   = out_res.error_code;

	urad_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.data_byte         (data_byte),
		.first_of_transfer (first_of_transfer),
		.transfer_length   (transfer_length),
		.q_st              (q_st),
		.push              (push),
		.push_res          (push_res)
	);

	urad_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.pop      (pop),
		.pop_res  (pop_res),
		.st       (q_st)
	);

	urad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_st      (q_st),
		.pop_res   (pop_res),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

endmodule

### sv/urad_front.sv
// Front part: accepts bytes, tracks the frame state and classifies each byte.
`include "assert_macros.svh"

module urad_front import urad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_of_transfer,
	input  logic [15:0] transfer_length,
	input  q_status_t   q_st,
	output logic        push,
	output res_t        push_res
);

	localparam logic [15:0] HDR_LAST  = 16'(HEADER_BYTES - 1);
	localparam logic [16:0] MIN_FRAME = 17'(HEADER_BYTES + DESCRIPTOR_BYTES + TRAILER_BYTES);
	localparam logic [15:0] TRL_LEN   = 16'(TRAILER_BYTES);
	localparam phase_t      AFTER_PAY = (TRAILER_BYTES > 0) ? PH_TRL : PH_HEAD;

	phase_t      phase_q, phase_d, ph_e;
	logic        rx_enable_q;
	logic [15:0] bc_q, bc_d, bc_e, bc_inc;
	logic [15:0] rem_q, rem_d, rem_e;
	logic [15:0] fl_q, fl_d, fl_e, fl_n;
	logic        accept;
	logic        last;
	err_t        err;

	assign in_stall = q_st.full;
	assign accept   = in_valid && !q_st.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_enable_q <= 1'b0;
			phase_q     <= PH_IDLE;
			bc_q        <= '0;
			rem_q       <= '0;
			fl_q        <= '0;
		end else begin
			if (cfg_valid) begin
				rx_enable_q <= cfg_data;
			end
			phase_q <= phase_d;
			bc_q    <= bc_d;
			rem_q   <= rem_d;
			fl_q    <= fl_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		bc_d     = bc_q;
		rem_d    = rem_q;
		fl_d     = fl_q;
		ph_e     = first_of_transfer ? PH_HEAD : phase_q;
		bc_e     = first_of_transfer ? 16'd0 : bc_q;
		rem_e    = first_of_transfer ? transfer_length : rem_q;
		fl_e     = first_of_transfer ? 16'd0 : fl_q;
		fl_n     = fl_e;
		bc_inc   = bc_e + 16'd1;
		last     = ({1'b0, bc_e} + 17'd1) >= {1'b0, fl_e};
		err      = ERR_NONE;
		push     = 1'b0;
		push_res = '{payload_byte: 8'h00, frame_last: 1'b0, error_code: ERR_NONE};
		if (accept) begin
			if (!rx_enable_q) begin
				phase_d = PH_IDLE;
			end else begin
				phase_d = ph_e;
				bc_d    = bc_e;
				rem_d   = rem_e;
				fl_d    = fl_e;
				if (ph_e == PH_IDLE || rem_e == 16'd0) begin
					phase_d = PH_IDLE;
				end else begin
					rem_d = rem_e - 16'd1;
					case (ph_e)
						PH_HEAD: begin
							if (bc_e == 16'd0) begin
								if ({1'b0, rem_e} < MIN_FRAME) begin
									err = ERR_SHORT;
								end
								fl_n = {8'h00, data_byte};
							end else if (bc_e == 16'd1) begin
								fl_n = {data_byte, fl_e[7:0]};
							end
							if (err == ERR_NONE) begin
								fl_d = fl_n;
								if (bc_e == HDR_LAST) begin
									if (fl_n == 16'd0) begin
										err = ERR_ZERO;
									end else if (fl_n >= rem_e) begin
										err = ERR_OVERRUN;
									end else if ((fl_n & LEN_ALIGN_MASK) != 16'd0) begin
										err = ERR_ALIGN;
									end else begin
										phase_d = PH_PAY;
										bc_d    = 16'd0;
									end
								end else begin
									bc_d = bc_inc;
								end
							end
						end
						PH_PAY: begin
							push     = 1'b1;
							push_res = '{payload_byte: data_byte, frame_last: last,
								error_code: ERR_NONE};
							if (last) begin
								bc_d    = 16'd0;
								phase_d = AFTER_PAY;
							end else begin
								bc_d = bc_inc;
							end
						end
						PH_TRL: begin
							if (bc_inc >= TRL_LEN) begin
								bc_d    = 16'd0;
								phase_d = PH_HEAD;
							end else begin
								bc_d = bc_inc;
							end
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
					if (err != ERR_NONE) begin
						push     = 1'b1;
						push_res = '{payload_byte: 8'h00, frame_last: 1'b0, error_code: err};
						phase_d  = PH_IDLE;
						bc_d     = 16'd0;
					end else if (rem_d == 16'd0) begin
						phase_d = PH_IDLE;
						bc_d    = 16'd0;
					end
				end
			end
		end
	end

	`URAD_ASSERT_NEXT(a_err_goes_idle, clk, arst_n,
		push && (push_res.error_code != ERR_NONE), phase_q == PH_IDLE)

endmodule

### sv/urad_queue.sv
// Short result queue between the front and back parts.
`include "assert_macros.svh"

module urad_queue import urad_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_t      push_res,
	input  logic      pop,
	output res_t      pop_res,
	output q_status_t st
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	res_t          mem_q [DEPTH];
	logic [IW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign st.full  = count_q == CW'(DEPTH);
	assign st.empty = count_q == '0;
	assign pop_res  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + IW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`URAD_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`URAD_ASSERT(a_no_push_full, clk, arst_n, !(push && st.full) && !(pop && st.empty))

endmodule

### sv/urad_back.sv
// Back part: drains the result queue into the output register.
module urad_back import urad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_st,
	input  res_t      pop_res,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output res_t      out_res
);

	logic out_valid_q;
	res_t out_res_q;

	assign pop       = !q_st.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= pop_res;
		end
	end

endmodule

### sim/testbench.sv
// Testbench for the receive deframer core: predicts each byte request and checks the results.
module testbench import urad_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 1700;
	localparam int MIN_START    = HEADER_BYTES + DESCRIPTOR_BYTES + TRAILER_BYTES;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        first_of_transfer = 1'b0;
	logic [15:0] transfer_length = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  payload_byte;
	logic        frame_last;
	logic [2:0]  error_code;

	// Predicted frame state, kept in step with every accepted request.
	bit          rx_en;
	phase_t      fr_phase;
	logic [15:0] sect_count;
	logic [16:0] bytes_left;
	logic [15:0] frame_len;
	res_t        deframed_q[$];

	logic [7:0]  xfer_bytes[$];
	int          send_gap_pct;
	int          recv_stall_pct;
	int          bytes_sent;
	int          mismatches;
	int          payload_seen;
	int          frame_ends;
	int          err_seen[5];
	int          enable_writes;
	bit          pressure_done;

	usb_rx_aggregate_deframer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.first_of_transfer(first_of_transfer),
		.transfer_length(transfer_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.frame_last(frame_last),
		.error_code(error_code)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic void frame_error(input err_t code);
		deframed_q.push_back('{payload_byte: 8'h00, frame_last: 1'b0, error_code: code});
		fr_phase = PH_IDLE;
		sect_count = '0;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic is_first,
			input logic [15:0] tlen);
		logic [16:0] left_before;
		logic        is_last;
		if (!rx_en) begin
			fr_phase = PH_IDLE;
			return;
		end
		if (is_first) begin
			bytes_left = {1'b0, tlen};
			fr_phase = PH_HEAD;
			sect_count = '0;
			frame_len = '0;
		end
		if (fr_phase == PH_IDLE || bytes_left == 0) begin
			fr_phase = PH_IDLE;
			return;
		end
		left_before = bytes_left;
		bytes_left = bytes_left - 17'd1;
		case (fr_phase)
			PH_HEAD: begin
				if (sect_count == 0) begin
					if (left_before < MIN_START) begin
						frame_error(ERR_SHORT);
						return;
					end
					frame_len = {8'h00, b};
				end else if (sect_count == 1) begin
					frame_len[15:8] = b;
				end
				if (sect_count == HEADER_BYTES - 1) begin
					if (frame_len == 0) begin
						frame_error(ERR_ZERO);
						return;
					end
					if (frame_len + HEADER_BYTES > left_before + HEADER_BYTES - 1) begin
						frame_error(ERR_OVERRUN);
						return;
					end
					if ((frame_len & LEN_ALIGN_MASK) != 0) begin
						frame_error(ERR_ALIGN);
						return;
					end
					fr_phase = PH_PAY;
					sect_count = '0;
				end else begin
					sect_count = sect_count + 16'd1;
				end
			end
			PH_PAY: begin
				is_last = (sect_count + 1 >= frame_len);
				deframed_q.push_back('{payload_byte: b, frame_last: is_last,
					error_code: ERR_NONE});
				if (is_last) begin
					sect_count = '0;
					fr_phase = (TRAILER_BYTES > 0) ? PH_TRL : PH_HEAD;
				end else begin
					sect_count = sect_count + 16'd1;
				end
			end
			PH_TRL: begin
				sect_count = sect_count + 16'd1;
				if (sect_count >= TRAILER_BYTES) begin
					sect_count = '0;
					fr_phase = PH_HEAD;
				end
			end
			default: ;
		endcase
		if (bytes_left == 0) begin
			fr_phase = PH_IDLE;
			sect_count = '0;
		end
	endfunction

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (deframed_q.size() == 0) begin
				$display("%0t: unexpected result byte=%02h last=%0b code=%0d", $time,
					payload_byte, frame_last, error_code);
				mismatches++;
			end else begin
				want = deframed_q.pop_front();
				if (payload_byte !== want.payload_byte) begin
					$display("%0t: payload_byte expected %02h, got %02h", $time,
						want.payload_byte, payload_byte);
					mismatches++;
				end
				if (frame_last !== want.frame_last) begin
					$display("%0t: frame_last expected %0b, got %0b", $time,
						want.frame_last, frame_last);
					mismatches++;
				end
				if (error_code !== want.error_code) begin
					$display("%0t: error_code expected %0d, got %0d", $time,
						want.error_code, error_code);
					mismatches++;
				end
				if (want.error_code == ERR_NONE) begin
					payload_seen++;
					if (want.frame_last)
						frame_ends++;
				end else begin
					err_seen[want.error_code]++;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic is_first, input logic [15:0] tlen);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_of_transfer <= is_first;
		transfer_length <= tlen;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_byte(b, is_first, tlen);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (deframed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_rx_enable(input bit value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		rx_en = value;
		enable_writes++;
	endtask

	function automatic void add_frame(input logic [15:0] len_field, input bit with_body);
		xfer_bytes.push_back(len_field[7:0]);
		xfer_bytes.push_back(len_field[15:8]);
		for (int k = 2; k < HEADER_BYTES; k++)
			xfer_bytes.push_back(8'($urandom));
		if (with_body) begin
			for (int k = 0; k < len_field; k++)
				xfer_bytes.push_back(8'($urandom));
			for (int k = 0; k < TRAILER_BYTES; k++)
				xfer_bytes.push_back(8'($urandom));
		end
	endfunction

	function automatic logic [15:0] pick_len(input int min_words);
		int pick;
		pick = $urandom_range(99);
		if (pick < 80)
			return 16'(4 * $urandom_range(min_words, 8));
		else if (pick < 97)
			return 16'(4 * $urandom_range(9, 32));
		return 16'(4 * $urandom_range(33, 200));
	endfunction

	task automatic send_xfer(input logic [15:0] tlen, input int from, input int upto);
		for (int i = from; i < upto; i++)
			send_byte(xfer_bytes[i], i == 0, (i == 0) ? tlen : 16'($urandom));
	endtask

	task automatic random_transfer();
		int          kind;
		int          nfr;
		int          half;
		logic [15:0] tlen;
		logic [15:0] bad_len;
		kind = $urandom_range(99);
		xfer_bytes.delete();
		if (kind < 60) begin
			nfr = $urandom_range(1, 3);
			for (int f = 0; f < nfr; f++)
				add_frame(pick_len((f == nfr - 1) ? 5 : 1), 1'b1);
			tlen = 16'(xfer_bytes.size());
			if ($urandom_range(99) < 15)
				tlen = tlen - 16'($urandom_range(1, TRAILER_BYTES));
			if ($urandom_range(99) < 20)
				repeat ($urandom_range(1, 3)) xfer_bytes.push_back(8'($urandom));
			if (!pressure_done) begin
				half = xfer_bytes.size() / 2;
				send_xfer(tlen, 0, half);
				wait_drained();
				send_xfer(tlen, half, xfer_bytes.size());
				pressure_done = 1'b1;
				return;
			end
		end else if (kind < 75) begin
			nfr = $urandom_range(0, 2);
			for (int f = 0; f < nfr; f++)
				add_frame(pick_len(1), 1'b1);
			case ($urandom_range(2))
				0: bad_len = 16'h0000;
				1: bad_len = 16'(4 * $urandom_range(1, 8) + $urandom_range(1, 3));
				default: bad_len = 16'($urandom) | 16'h0400;
			endcase
			add_frame(bad_len, 1'b0);
			repeat ($urandom_range(24, 40)) xfer_bytes.push_back(8'($urandom));
			tlen = 16'(xfer_bytes.size());
		end else if (kind < 85) begin
			tlen = 16'($urandom_range(0, MIN_START - 1));
			repeat ($urandom_range(1, 4)) xfer_bytes.push_back(8'($urandom));
		end else if (kind < 93) begin
			add_frame(pick_len(1), 1'b1);
			tlen = 16'($urandom_range(xfer_bytes.size() + MIN_START, 65535));
		end else begin
			repeat ($urandom_range(1, 12))
				send_byte(8'($urandom), $urandom_range(9) == 0, 16'($urandom));
			return;
		end
		send_xfer(tlen, 0, xfer_bytes.size());
	endtask

	// Cut a transfer off by disabling reception halfway; the rest must be dropped.
	task automatic disable_midway();
		int half;
		xfer_bytes.delete();
		add_frame(pick_len(5), 1'b1);
		half = xfer_bytes.size() / 2;
		send_xfer(16'(xfer_bytes.size()), 0, half);
		set_rx_enable(1'b0);
		repeat (2) send_byte(8'($urandom), 1'b0, 16'($urandom));
		set_rx_enable(1'b1);
		send_xfer(16'(xfer_bytes.size()), half, xfer_bytes.size());
	endtask

	task automatic test_disabled_drop();
		send_byte(8'h10, 1'b1, 16'd24);
		send_byte(8'h00, 1'b0, 16'hFFFF);
		send_byte(8'hFF, 1'b0, 16'h0000);
	endtask

	task automatic test_min_frame();
		set_rx_enable(1'b1);
		xfer_bytes.delete();
		add_frame(16'd16, 1'b1);
		xfer_bytes[HEADER_BYTES] = 8'h00;
		xfer_bytes[HEADER_BYTES + 1] = 8'hFF;
		send_xfer(16'(MIN_START), 0, xfer_bytes.size());
	endtask

	task automatic test_frame_errors();
		xfer_bytes.delete();
		add_frame(16'h0000, 1'b0);
		send_xfer(16'hFFFF, 0, HEADER_BYTES);
		xfer_bytes.delete();
		add_frame(16'hFFFF, 1'b0);
		send_xfer(16'(MIN_START), 0, HEADER_BYTES);
		xfer_bytes.delete();
		add_frame(16'd17, 1'b0);
		send_xfer(16'd40, 0, HEADER_BYTES);
		send_byte(8'h08, 1'b1, 16'(MIN_START - 1));
		send_byte(8'h08, 1'b1, 16'h0000);
		send_byte(8'h55, 1'b0, 16'd24);
	endtask

	task automatic test_random_traffic();
		int gap_mix[4];
		int stall_mix[4];
		int target;
		gap_mix = '{0, 56, 0, 16};
		stall_mix = '{0, 0, 56, 16};
		for (int p = 0; p < 4; p++) begin
			send_gap_pct = gap_mix[p];
			recv_stall_pct = stall_mix[p];
			disable_midway();
			target = bytes_sent + RANDOM_BYTES / 4;
			while (bytes_sent < target)
				random_transfer();
			wait_drained();
		end
	endtask

	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding", deframed_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		rx_en = 1'b0;
		fr_phase = PH_IDLE;
		sect_count = '0;
		bytes_left = '0;
		frame_len = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled_drop();
		test_min_frame();
		test_frame_errors();
		test_random_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes over four idle and stall mixes, %0d enable writes.",
			bytes_sent, enable_writes);
		$display("Saw %0d payload bytes in %0d frames; errors short %0d, zero %0d, %s %0d/%0d.",
			payload_seen, frame_ends, err_seen[ERR_SHORT], err_seen[ERR_ZERO],
			"overrun/align", err_seen[ERR_OVERRUN], err_seen[ERR_ALIGN]);
		if (mismatches == 0 && deframed_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
